FILE: rtl/pmau_pkg.sv
package pmau_pkg;
  localparam int MEM_BYTES = 1048576;
  localparam int AW = $clog2(MEM_BYTES);

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_NOT_PRESENT = 2'd1;
  localparam logic [1:0] ST_RANGE       = 2'd2;
  localparam logic [1:0] ST_CROSS_WRITE = 2'd3;

  localparam logic [31:0] BIT_PRESENT  = 32'h1;
  localparam logic [31:0] BIT_ACCESSED = 32'h20;
  localparam logic [31:0] BIT_DIRTY    = 32'h40;

  localparam logic [1:0] CFG_PAGING  = 2'd0;
  localparam logic [1:0] CFG_DIRBASE = 2'd1;

  // datapath commands
  typedef struct packed {
    logic load;      // capture the input transaction
    logic next_pc;   // save the first piece and advance to the second
    logic sel_de;    // point cursor at the directory entry
    logic sel_te;    // point cursor at the table entry
    logic sel_data;  // point cursor at the data bytes of the current piece
    logic rd;        // issue a byte read at the cursor
    logic shift_in;  // place the byte read last cycle into the word
    logic upd_de;    // set accessed in the directory word, rewind cursor
    logic upd_te;    // set accessed (and dirty on writes) in the table word
    logic wr;        // write one byte of the word at the cursor
    logic finish;    // strobe result
    logic [1:0] fst; // status for finish
  } pmau_cmd_t;

  typedef struct packed {
    logic op;
    logic paging;
    logic crosses;
    logic second;
    logic present;
    logic de_need;
    logic te_need;
    logic range_ok;   // current target lies inside the store
    logic issue_done; // all bytes of the target have been issued
    logic last_byte;
  } pmau_stat_t;
endpackage

FILE: rtl/pmau_datapath.sv
module pmau_datapath (
  input  logic                clk,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [19:0]         cfg_wdata,
  input  logic                rst_n,
  input  logic                in_op,
  input  logic [31:0]         in_addr,
  input  logic [2:0]          in_len,
  input  logic [31:0]         in_wdata,
  input  pmau_pkg::pmau_cmd_t cmd,
  output pmau_pkg::pmau_stat_t stat,
  output logic                out_valid,
  output logic [31:0]         out_rdata,
  output logic [1:0]          out_status
);
  import pmau_pkg::*;

  logic [7:0]  mem [MEM_BYTES];
  logic        paging_r;
  logic [19:0] dir_r;
  logic        op_r;
  logic [31:0] va_r, wd_r, word_r, acc_r;
  logic [31:0] cur_r, base_r;
  logic [2:0]  len_r, plen_r, lolen_r, span_r, cnt_r, ic_r;
  logic        second_r, crosses_r;
  logic [7:0]  rbyte_r;
  logic        valid_r;
  logic [31:0] rd_r;
  logic [1:0]  st_r;

  logic [2:0]  nlen;
  logic [12:0] endoff;
  logic [2:0]  lo_room;
  logic [31:0] de_a, te_a, data_a;
  always_comb begin
    nlen = (in_len == 3'd0) ? 3'd1 : (in_len > 3'd4) ? 3'd4 : in_len;
    endoff = {1'b0, in_addr[11:0]} + {10'd0, nlen};
    lo_room = 3'(13'h1000 - {1'b0, in_addr[11:0]});
    de_a = {dir_r, va_r[31:22], 2'b00};
    te_a = {word_r[31:12], va_r[21:12], 2'b00};
    data_a = paging_r ? {word_r[31:12], va_r[11:0]} : va_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      paging_r <= 1'b0;
      dir_r    <= '0;
      valid_r  <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == CFG_PAGING) paging_r <= cfg_wdata[0];
      if (cfg_we && cfg_index == CFG_DIRBASE) dir_r <= cfg_wdata;
      valid_r <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_op; va_r <= in_addr; wd_r <= in_wdata; len_r <= nlen;
      crosses_r <= endoff > 13'h1000;
      second_r <= 1'b0;
      // split a page-crossing read into two pieces when paging is on
      if (paging_r && endoff > 13'h1000 && !in_op) begin
        lolen_r <= lo_room;
        plen_r  <= lo_room;
      end else begin
        lolen_r <= 3'd0;
        plen_r  <= nlen;
      end
    end else if (cmd.next_pc) begin
      second_r <= 1'b1;
      va_r <= va_r + {29'd0, lolen_r};
      plen_r <= len_r - lolen_r;
    end
    if (cmd.next_pc) acc_r <= word_r;

    if (cmd.sel_de) begin
      cur_r <= de_a; base_r <= de_a; span_r <= 3'd4;
    end else if (cmd.sel_te) begin
      cur_r <= te_a; base_r <= te_a; span_r <= 3'd4;
    end else if (cmd.sel_data) begin
      cur_r <= data_a; base_r <= data_a; span_r <= plen_r;
    end else if (cmd.upd_de || cmd.upd_te) begin
      cur_r <= base_r;
    end else if (cmd.rd || cmd.wr) begin
      cur_r <= cur_r + 32'd1;
    end

    if (cmd.sel_de || cmd.sel_te || cmd.sel_data) ic_r <= 3'd0;
    else if (cmd.rd) ic_r <= ic_r + 3'd1;

    if (cmd.sel_de || cmd.sel_te || cmd.sel_data || cmd.upd_de || cmd.upd_te)
      cnt_r <= 3'd0;
    else if (cmd.shift_in || cmd.wr)
      cnt_r <= cnt_r + 3'd1;

    if (cmd.sel_data) word_r <= op_r ? wd_r : 32'd0;
    else if (cmd.upd_de) word_r <= word_r | BIT_ACCESSED;
    else if (cmd.upd_te) word_r <= word_r | BIT_ACCESSED | (op_r ? BIT_DIRTY : 32'd0);
    else if (cmd.shift_in) word_r[{cnt_r[1:0], 3'b000} +: 8] <= rbyte_r;

    if (cmd.finish) begin
      st_r <= cmd.fst;
      if (cmd.fst != ST_OK || op_r) rd_r <= 32'd0;
      else if (second_r) rd_r <= acc_r | (word_r << {lolen_r, 3'b000});
      else rd_r <= word_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) mem[cur_r[AW-1:0]] <= word_r[{cnt_r[1:0], 3'b000} +: 8];
    if (cmd.rd) rbyte_r <= mem[cur_r[AW-1:0]];
  end

  always_comb begin
    stat.op = op_r;
    stat.paging = paging_r;
    stat.crosses = crosses_r;
    stat.second = second_r;
    stat.present = (word_r & BIT_PRESENT) != 32'd0;
    stat.de_need = (word_r & BIT_ACCESSED) == 32'd0;
    stat.te_need = (word_r & BIT_ACCESSED) == 32'd0 ||
                   (op_r && (word_r & BIT_DIRTY) == 32'd0);
    stat.range_ok = ({1'b0, base_r} + {30'd0, span_r}) <= 33'(MEM_BYTES);
    stat.issue_done = ic_r == span_r;
    stat.last_byte = cnt_r == span_r - 3'd1;
  end

  assign out_valid  = valid_r;
  assign out_rdata  = rd_r;
  assign out_status = st_r;
endmodule

FILE: rtl/pmau_ctrl.sv
module pmau_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  pmau_pkg::pmau_stat_t stat,
  output pmau_pkg::pmau_cmd_t  cmd
);
  import pmau_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0, S_PIECE = 4'd1, S_DE_CHK = 4'd2, S_DE_RD = 4'd3,
    S_DE_EV = 4'd4, S_DE_WB = 4'd5, S_TE_CHK = 4'd6, S_TE_RD = 4'd7, S_TE_EV = 4'd8,
    S_TE_WB = 4'd9, S_DAT_CHK = 4'd10, S_DAT_RD = 4'd11, S_DAT_WR = 4'd12,
    S_DAT_END = 4'd13;

  logic [3:0] st_r, st_nxt;

  assign busy = st_r != S_IDLE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    cmd = '0;
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (start) begin cmd.load = 1'b1; st_nxt = S_PIECE; end
      S_PIECE: begin
        if (stat.op && stat.paging && stat.crosses) begin
          cmd.finish = 1'b1; cmd.fst = ST_CROSS_WRITE; st_nxt = S_IDLE;
        end else if (stat.paging) begin
          cmd.sel_de = 1'b1; st_nxt = S_DE_CHK;
        end else begin
          cmd.sel_data = 1'b1; st_nxt = S_DAT_CHK;
        end
      end
      // entry word: range check, then issue the first byte read
      S_DE_CHK, S_TE_CHK: begin
        if (!stat.range_ok) begin
          cmd.finish = 1'b1; cmd.fst = ST_RANGE; st_nxt = S_IDLE;
        end else begin
          cmd.rd = 1'b1;
          st_nxt = (st_r == S_DE_CHK) ? S_DE_RD : S_TE_RD;
        end
      end
      // keep reads one byte ahead of the accumulation
      S_DE_RD, S_TE_RD, S_DAT_RD: begin
        cmd.rd = !stat.issue_done;
        cmd.shift_in = 1'b1;
        if (stat.last_byte)
          st_nxt = (st_r == S_DE_RD) ? S_DE_EV : (st_r == S_TE_RD) ? S_TE_EV : S_DAT_END;
      end
      S_DE_EV: begin
        if (!stat.present) begin
          cmd.finish = 1'b1; cmd.fst = ST_NOT_PRESENT; st_nxt = S_IDLE;
        end else if (stat.de_need) begin
          cmd.upd_de = 1'b1; st_nxt = S_DE_WB;
        end else begin
          cmd.sel_te = 1'b1; st_nxt = S_TE_CHK;
        end
      end
      S_TE_EV: begin
        if (!stat.present) begin
          cmd.finish = 1'b1; cmd.fst = ST_NOT_PRESENT; st_nxt = S_IDLE;
        end else if (stat.te_need) begin
          cmd.upd_te = 1'b1; st_nxt = S_TE_WB;
        end else begin
          cmd.sel_data = 1'b1; st_nxt = S_DAT_CHK;
        end
      end
      // write the entry back, then evaluate it again with the bits set
      S_DE_WB, S_TE_WB: begin
        cmd.wr = 1'b1;
        if (stat.last_byte) st_nxt = (st_r == S_DE_WB) ? S_DE_EV : S_TE_EV;
      end
      S_DAT_CHK: begin
        if (!stat.range_ok) begin
          cmd.finish = 1'b1; cmd.fst = ST_RANGE; st_nxt = S_IDLE;
        end else if (stat.op) begin
          st_nxt = S_DAT_WR;
        end else begin
          cmd.rd = 1'b1; st_nxt = S_DAT_RD;
        end
      end
      S_DAT_WR: begin
        cmd.wr = 1'b1;
        if (stat.last_byte) begin
          cmd.finish = 1'b1; cmd.fst = ST_OK; st_nxt = S_IDLE;
        end
      end
      S_DAT_END: begin
        if (stat.crosses && stat.paging && !stat.second) begin
          cmd.next_pc = 1'b1; st_nxt = S_PIECE;
        end else begin
          cmd.finish = 1'b1; cmd.fst = ST_OK; st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end
endmodule

FILE: rtl/paged_memory_access_unit.sv
// Paged memory access unit.
// Issue a transaction by raising start while busy is low, with in_op,
// in_addr, in_len and in_wdata valid in that cycle. busy stays high until
// the result is out. The result appears on out_rdata and out_status for
// exactly one cycle, flagged by out_valid; the receiver cannot stall it.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) land at the clock
// edge and must only be issued while busy is low.
// The single-port byte store moves one byte per cycle, with reads pipelined.
// An entry is written back when its accessed or dirty bit changes. A
// page-crossing read does two walks, with up to four writebacks. A
// page-crossing write with paging on answers with ST_CROSS_WRITE and no
// walk; faults end the walk early. busy drops in the result cycle, so the
// next transaction can be accepted at the edge that ends it.
// Reset (synchronous, rst_n low) clears the paging enable, the directory
// frame, out_valid and the controller. The byte store is not cleared.
module paged_memory_access_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_op,
  input  logic [31:0] in_addr,
  input  logic [2:0]  in_len,
  input  logic [31:0] in_wdata,
  output logic        out_valid,
  output logic [31:0] out_rdata,
  output logic [1:0]  out_status,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_wdata
);
  import pmau_pkg::*;

  pmau_cmd_t  cmd;
  pmau_stat_t stat;

  pmau_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .stat(stat), .cmd(cmd)
  );

  pmau_datapath u_dp (
    .clk(clk), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .rst_n(rst_n), .in_op(in_op), .in_addr(in_addr), .in_len(in_len),
    .in_wdata(in_wdata), .cmd(cmd), .stat(stat), .out_valid(out_valid),
    .out_rdata(out_rdata), .out_status(out_status)
  );
endmodule
